>>> rtl/fwse_pkg.sv
// ----------------------------------------------------------------------------
// fwse_pkg
// Types, constants and the crc helper of the floppy write stream encoder.
// ----------------------------------------------------------------------------
package fwse_pkg;

  localparam int CNT_W            = 11;
  localparam int MAX_SECTOR_BYTES = 1024;
  localparam int SECTOR_BASE      = 128;
  localparam int IDX_W            = 4;

  // configuration register indexes
  localparam logic REG_DOUBLE_DENSITY = 1'b0;
  localparam logic REG_SECTOR_SIZE    = 1'b1;

  typedef enum logic [1:0] {
    OP_TRACK = 2'd0,
    OP_BEGIN = 2'd1,
    OP_DATA  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    BURST_SECTOR,
    BURST_DATA,
    BURST_CRC,
    BURST_WORD
  } burst_kind_t;

  // one burst of disk words waiting to go out
  typedef struct packed {
    burst_kind_t            kind;
    logic                   mfm;
    logic [IDX_W-1:0]       final_idx;
    logic [15:0]            word;
    logic [15:0]            crc;
  } burst_t;

  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_AFTER_SYNC = 16'hCDB4;
  localparam logic [15:0] WORD_SYNC_A1   = 16'hFFA1;
  localparam logic [15:0] WORD_SYNC_C2   = 16'hFFC2;
  localparam logic [15:0] MARK_FLAG      = 16'hFF00;
  localparam logic [15:0] WORD_GAP_END   = 16'h00FF;
  localparam logic [15:0] WORD_ZERO      = 16'h0000;

  localparam logic [7:0] BYTE_CRC      = 8'hF7;
  localparam logic [7:0] BYTE_SYNC_A1  = 8'hF5;
  localparam logic [7:0] BYTE_SYNC_C2  = 8'hF6;
  localparam logic [7:0] BYTE_INDEX    = 8'hFC;
  localparam logic [7:0] BYTE_ID       = 8'hFE;
  localparam logic [7:0] MARK_DELETED  = 8'hF8;
  localparam logic [7:0] MARK_F9       = 8'hF9;
  localparam logic [7:0] MARK_FA       = 8'hFA;
  localparam logic [7:0] MARK_NORMAL   = 8'hFB;

  localparam logic [IDX_W-1:0] ZEROS_MFM = 4'd12;
  localparam logic [IDX_W-1:0] ZEROS_FM  = 4'd6;
  localparam logic [IDX_W-1:0] FINAL_MFM = 4'd15;
  localparam logic [IDX_W-1:0] FINAL_FM  = 4'd6;
  localparam logic [IDX_W-1:0] FINAL_ONE = 4'd0;
  localparam logic [IDX_W-1:0] FINAL_CRC = 4'd1;
  localparam logic [IDX_W-1:0] FINAL_END = 4'd3;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // crc-16-ccitt over one byte, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/fwse_if.sv
// ----------------------------------------------------------------------------
// fwse stream interfaces
// Host item channel and disk word channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fwse_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_byte;
  logic       deleted_mark;

  modport source (output valid, output operation, output data_byte,
                  output deleted_mark, input ready);
  modport sink   (input valid, input operation, input data_byte,
                  input deleted_mark, output ready);
endinterface

interface fwse_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] disk_word;
  logic        last;

  modport source (output valid, output disk_word, output last, input ready);
  modport sink   (input valid, input disk_word, input last, output ready);
endinterface

>>> rtl/floppy_write_stream_encoder.sv
// ----------------------------------------------------------------------------
// floppy_write_stream_encoder
// Turns host bytes into fm/mfm disk words, keeping the sector crc and count.
// ----------------------------------------------------------------------------
// latency: first disk word of an item is valid the cycle after its transfer
// throughput: one disk word per cycle while results.ready is high; an item that
//   makes one word is then taken every cycle, a burst holds the input until its
//   last word is taken (16 words mfm sector header, 7 fm, 4 sector end, 2 crc)
// reset: synchronous; crc to all ones, count to zero, fm, size code 2, no burst
module floppy_write_stream_encoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [1:0]        cfg_data,
  fwse_item_if.sink         items,
  fwse_word_if.source       results
);

  logic                                  double_density;
  logic [1:0]                            sector_size_code;
  logic [15:0]                           running_crc;
  logic [15:0]                           running_crc_next;
  logic [fwse_pkg::CNT_W-1:0]            byte_count;
  logic [fwse_pkg::CNT_W-1:0]            byte_count_next;
  logic                                  busy;
  logic [fwse_pkg::IDX_W-1:0]            idx;
  fwse_pkg::burst_t                      burst;
  fwse_pkg::burst_t                      burst_next;
  logic                                  load;

  logic                                  in_fire;
  logic                                  out_fire;
  logic                                  out_last;
  logic [fwse_pkg::CNT_W-1:0]            sector_len;
  logic [fwse_pkg::CNT_W-1:0]            count_inc;
  logic [15:0]                           crc_data;
  logic [15:0]                           crc_seed;
  logic [7:0]                            mark;
  logic [15:0]                           word_out;

  assign in_fire  = items.valid & items.ready;
  assign out_fire = results.valid & results.ready;
  assign out_last = (idx == burst.final_idx);

  assign items.ready       = !busy | (results.ready & out_last);
  assign results.valid     = busy;
  assign results.disk_word = word_out;
  assign results.last      = out_last;

  // sector length, capped
  always_comb begin
    sector_len = fwse_pkg::CNT_W'(fwse_pkg::SECTOR_BASE) << sector_size_code;
    if (sector_len > fwse_pkg::CNT_W'(fwse_pkg::MAX_SECTOR_BYTES)) begin
      sector_len = fwse_pkg::CNT_W'(fwse_pkg::MAX_SECTOR_BYTES);
    end
  end

  assign count_inc = byte_count + 1'b1;
  assign crc_data  = fwse_pkg::crc_byte(running_crc, items.data_byte);
  assign mark      = items.deleted_mark ? fwse_pkg::MARK_DELETED : fwse_pkg::MARK_NORMAL;
  assign crc_seed  = double_density ? fwse_pkg::CRC_AFTER_SYNC : fwse_pkg::CRC_INIT;

  // state update and burst descriptor for the incoming item
  always_comb begin
    running_crc_next     = running_crc;
    byte_count_next      = byte_count;
    load                 = 1'b0;
    burst_next.kind      = fwse_pkg::BURST_WORD;
    burst_next.mfm       = double_density;
    burst_next.final_idx = fwse_pkg::FINAL_ONE;
    burst_next.word      = {8'h00, items.data_byte};
    burst_next.crc       = running_crc;
    case (items.operation)
      fwse_pkg::OP_BEGIN: begin
        load                 = 1'b1;
        burst_next.kind      = fwse_pkg::BURST_SECTOR;
        burst_next.final_idx = double_density ? fwse_pkg::FINAL_MFM : fwse_pkg::FINAL_FM;
        burst_next.word      = {8'h00, mark} | (double_density ? fwse_pkg::WORD_ZERO
                                                              : fwse_pkg::MARK_FLAG);
        running_crc_next     = fwse_pkg::crc_byte(crc_seed, mark);
        byte_count_next      = '0;
      end
      fwse_pkg::OP_DATA: begin
        load             = 1'b1;
        burst_next.kind  = fwse_pkg::BURST_DATA;
        burst_next.crc   = crc_data;
        running_crc_next = crc_data;
        if (count_inc >= sector_len) begin
          burst_next.final_idx = fwse_pkg::FINAL_END;
          byte_count_next      = '0;
        end else begin
          byte_count_next      = count_inc;
        end
      end
      fwse_pkg::OP_TRACK: begin
        load = 1'b1;
        if (items.data_byte == fwse_pkg::BYTE_CRC) begin
          burst_next.kind      = fwse_pkg::BURST_CRC;
          burst_next.final_idx = fwse_pkg::FINAL_CRC;
        end else if (double_density) begin
          if (items.data_byte == fwse_pkg::BYTE_SYNC_A1) begin
            burst_next.word  = fwse_pkg::WORD_SYNC_A1;
            running_crc_next = fwse_pkg::CRC_AFTER_SYNC;
          end else if (items.data_byte == fwse_pkg::BYTE_SYNC_C2) begin
            burst_next.word  = fwse_pkg::WORD_SYNC_C2;
          end else begin
            running_crc_next = crc_data;
          end
        end else begin
          if (items.data_byte inside {fwse_pkg::BYTE_ID, fwse_pkg::MARK_DELETED,
                                      fwse_pkg::MARK_F9, fwse_pkg::MARK_FA,
                                      fwse_pkg::MARK_NORMAL}) begin
            running_crc_next = fwse_pkg::crc_byte(fwse_pkg::CRC_INIT, items.data_byte);
            burst_next.word  = fwse_pkg::MARK_FLAG | {8'h00, items.data_byte};
          end else if (items.data_byte == fwse_pkg::BYTE_INDEX) begin
            burst_next.word  = fwse_pkg::MARK_FLAG | {8'h00, items.data_byte};
          end else begin
            running_crc_next = crc_data;
          end
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  // word selection within the current burst
  always_comb begin
    word_out = fwse_pkg::WORD_ZERO;
    case (burst.kind)
      fwse_pkg::BURST_SECTOR: begin
        if (idx < (burst.mfm ? fwse_pkg::ZEROS_MFM : fwse_pkg::ZEROS_FM)) begin
          word_out = fwse_pkg::WORD_ZERO;
        end else if (idx == burst.final_idx) begin
          word_out = burst.word;
        end else begin
          word_out = fwse_pkg::WORD_SYNC_A1;
        end
      end
      fwse_pkg::BURST_DATA: begin
        case (idx)
          4'd0:    word_out = burst.word;
          4'd1:    word_out = {8'h00, burst.crc[15:8]};
          4'd2:    word_out = {8'h00, burst.crc[7:0]};
          default: word_out = fwse_pkg::WORD_GAP_END;
        endcase
      end
      fwse_pkg::BURST_CRC: begin
        word_out = (idx == '0) ? {8'h00, burst.crc[15:8]} : {8'h00, burst.crc[7:0]};
      end
      default: begin
        word_out = burst.word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      double_density   <= 1'b0;
      sector_size_code <= 2'd2;
    end else if (cfg_write) begin
      case (cfg_index)
        fwse_pkg::REG_DOUBLE_DENSITY: double_density   <= cfg_data[0];
        fwse_pkg::REG_SECTOR_SIZE:    sector_size_code <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= fwse_pkg::CRC_INIT;
      byte_count  <= '0;
      busy        <= 1'b0;
      idx         <= '0;
    end else begin
      if (in_fire) begin
        running_crc <= running_crc_next;
        byte_count  <= byte_count_next;
      end
      if (in_fire && load) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (out_fire) begin
        if (out_last) begin
          busy <= 1'b0;
          idx  <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  // burst payload needs no reset
  always_ff @(posedge clk) begin
    if (in_fire && load) begin
      burst <= burst_next;
    end
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    byte_count < fwse_pkg::CNT_W'(fwse_pkg::MAX_SECTOR_BYTES))
    else $error("sector byte count out of range");

  a_hold_mid_burst: assert property (@(posedge clk) disable iff (rst)
    busy && !out_last |-> !items.ready)
    else $error("input taken in the middle of a burst");

  a_header_loads: assert property (@(posedge clk) disable iff (rst)
    in_fire && items.operation == fwse_pkg::OP_BEGIN
    |=> busy && idx == '0 && burst.kind == fwse_pkg::BURST_SECTOR)
    else $error("sector header burst not started");

  a_idx_bounded: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= burst.final_idx)
    else $error("burst index ran past its final word");

endmodule
